>>> rtl/clsr_pkg.sv
`default_nettype none
package clsr_pkg;

  localparam int unsigned VAL_W = 31;

  localparam logic [VAL_W-1:0] MOD_ONE     = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD_TWO     = 31'd2147483399;
  localparam logic [15:0]      MUL_ONE     = 16'd40014;
  localparam logic [15:0]      MUL_TWO     = 16'd40692;
  localparam logic [VAL_W-1:0] OUT_MAX     = 31'd2147483562;
  localparam logic [VAL_W-1:0] GEN_ONE_RST = 31'd1;
  localparam logic [VAL_W-1:0] GEN_TWO_RST = 31'd123456789;
  localparam logic [VAL_W-1:0] SEED_ZERO_SUB = 31'd1;

  localparam int unsigned WARMUP_EXTRA = 8;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_SEED = 1'b1
  } op_e;

endpackage
`default_nettype wire

>>> rtl/clsr_ram.sv
`default_nettype none
module clsr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/clsr_mulmod.sv
`default_nettype none
module clsr_mulmod #(
  parameter logic [30:0] MOD = clsr_pkg::MOD_ONE,
  parameter logic [15:0] MUL = clsr_pkg::MUL_ONE
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [30:0] x_i,
  output logic      [30:0] y_o
);

  localparam logic [31:0] FOLD32 = 32'h8000_0000 - {1'b0, MOD};
  localparam logic [7:0]  FOLD   = FOLD32[7:0];

  logic [46:0] prod_q;
  logic [15:0] hi;
  logic [30:0] lo;
  logic [23:0] fold;
  logic [31:0] sum;
  logic [31:0] red;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {16'd0, x_i} * {31'd0, MUL};
    end
  end

  // 2^31 is congruent to FOLD, so one conditional subtract finishes the reduction
  always_comb begin
    hi   = prod_q[46:31];
    lo   = prod_q[30:0];
    fold = {8'd0, hi} * {16'd0, FOLD};
    sum  = {1'b0, lo} + {8'd0, fold};
    red  = (sum >= {1'b0, MOD}) ? (sum - {1'b0, MOD}) : sum;
  end

  assign y_o = red[30:0];

endmodule
`default_nettype wire

>>> rtl/clsr_bin.sv
`default_nettype none
module clsr_bin #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [30:0]                    x_i,
  output logic      [$clog2(TABLE_DEPTH)-1:0] idx_o
);

  localparam longint unsigned BIN_DIV = 64'd1 + 64'd2147483562 / 64'(TABLE_DEPTH);
  localparam int unsigned     SH      = 40;
  localparam longint unsigned RECIP   = (64'd1 << SH) / BIN_DIV;
  localparam int unsigned     RW      = $clog2(RECIP + 1);
  localparam int unsigned     PW      = 31 + RW;
  localparam int unsigned     BW      = $clog2(BIN_DIV + 1);
  localparam int unsigned     AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned     QW      = AW + 2;
  localparam int unsigned     CW      = QW + BW;

  logic [PW-1:0] prod_q;
  logic [QW-1:0] q_est;
  logic [QW-1:0] q_up;
  logic [CW-1:0] bound;
  logic [QW-1:0] q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(x_i) * PW'(RECIP);
    end
  end

  // estimate is exact or one low; correct it, then clamp to the last entry
  always_comb begin
    q_est = QW'(prod_q >> SH);
    q_up  = q_est + QW'(1);
    bound = CW'(q_up) * CW'(BIN_DIV);
    q     = (CW'(x_i) >= bound) ? q_up : q_est;
    if (q >= QW'(TABLE_DEPTH)) begin
      idx_o = AW'(TABLE_DEPTH - 1);
    end else begin
      idx_o = q[AW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/combined_lcg_shuffle_rng_top.sv
`default_nettype none
// Combined two-generator random source with a shuffle table (ran2 style), integer output
// 1..2147483562. op 0 draws the next value; op 1 reseeds (0 is taken as 1), runs the first
// generator through TABLE_DEPTH+8 warm-up steps into the table, and then draws. A draw runs
// from acceptance through S_DRAW_A, S_DRAW_B and S_DRAW_C: the bin index of the last output
// goes through a reciprocal multiply and correction, one registered read of the table
// follows, and the write-back of the new first-generator value, held until the output
// register is free, completes the transaction. Each warm-up step of a seed passes through
// S_SEED_MUL and S_SEED_RED of the first generator's modular step unit. The result sits in an
// output register, so the next transaction may be accepted while a result still waits.
module combined_lcg_shuffle_rng_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [30:0] seed_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [30:0] rand_out_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_RED,
    S_DRAW_A,
    S_DRAW_B,
    S_DRAW_C
  } state_e;

  state_e                 state_q, state_d;
  logic [30:0]            gen_one_q, gen_one_d;
  logic [30:0]            gen_two_q, gen_two_d;
  logic [30:0]            last_out_q, last_out_d;
  logic [30:0]            out_data_q, out_data_d;
  logic                   out_valid_q, out_valid_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  logic          step_one_en;
  logic          step_two_en;
  logic          bin_en;
  logic [30:0]   step_one_y;
  logic [30:0]   step_two_y;
  logic [AW-1:0] bin_idx;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [30:0]   ram_wdata;
  logic          ram_re;
  logic [30:0]   ram_rdata;
  logic [30:0]   entry;
  logic [32:0]   diff;
  logic [32:0]   draw_val;
  logic [30:0]   rand_next;
  logic [30:0]   seed_fix;
  logic          out_free;

  clsr_mulmod #(
    .MOD (clsr_pkg::MOD_ONE),
    .MUL (clsr_pkg::MUL_ONE)
  ) u_step_one (
    .clk_i (clk_i),
    .en_i  (step_one_en),
    .x_i   (gen_one_q),
    .y_o   (step_one_y)
  );

  clsr_mulmod #(
    .MOD (clsr_pkg::MOD_TWO),
    .MUL (clsr_pkg::MUL_TWO)
  ) u_step_two (
    .clk_i (clk_i),
    .en_i  (step_two_en),
    .x_i   (gen_two_q),
    .y_o   (step_two_y)
  );

  clsr_bin #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_bin (
    .clk_i (clk_i),
    .en_i  (bin_en),
    .x_i   (last_out_q),
    .idx_o (bin_idx)
  );

  clsr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (bin_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    step_one_en = (state_q == S_SEED_MUL) || (state_q == S_DRAW_A);
    step_two_en = (state_q == S_DRAW_A);
    bin_en      = (state_q == S_DRAW_A);
    ram_re      = (state_q == S_DRAW_B);
    out_free    = !out_valid_q || out_ready_i;
    seed_fix    = (seed_value_i == '0) ? clsr_pkg::SEED_ZERO_SUB : seed_value_i;

    // entries never written read as zero
    entry     = valid_q[idx_q] ? ram_rdata : '0;
    diff      = {2'b00, entry} - {2'b00, gen_two_q};
    draw_val  = (diff[32] || (diff == '0)) ? (diff + {2'b00, clsr_pkg::OUT_MAX}) : diff;
    rand_next = draw_val[30:0];

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = gen_one_q;
    if (state_q == S_SEED_RED) begin
      ram_we    = (cnt_q < CNTW'(TABLE_DEPTH));
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = step_one_y;
    end else if (state_q == S_DRAW_C) begin
      ram_we = out_free;
    end

    state_d     = state_q;
    gen_one_d   = gen_one_q;
    gen_two_d   = gen_two_q;
    last_out_d  = last_out_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    valid_d     = valid_q;

    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == clsr_pkg::OP_SEED) begin
            gen_one_d = seed_fix;
            gen_two_d = seed_fix;
            cnt_d     = CNTW'(TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA - 1);
            state_d   = S_SEED_MUL;
          end else begin
            state_d = S_DRAW_A;
          end
        end
      end
      S_SEED_MUL: begin
        state_d = S_SEED_RED;
      end
      S_SEED_RED: begin
        gen_one_d = step_one_y;
        if (cnt_q == '0) begin
          last_out_d = step_one_y;
          state_d    = S_DRAW_A;
        end else begin
          cnt_d   = cnt_q - CNTW'(1);
          state_d = S_SEED_MUL;
        end
      end
      S_DRAW_A: begin
        state_d = S_DRAW_B;
      end
      S_DRAW_B: begin
        gen_one_d = step_one_y;
        gen_two_d = step_two_y;
        idx_d     = bin_idx;
        state_d   = S_DRAW_C;
      end
      S_DRAW_C: begin
        // hold until the output register is free
        if (out_free) begin
          last_out_d  = rand_next;
          out_data_d  = rand_next;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_one_q   <= clsr_pkg::GEN_ONE_RST;
      gen_two_q   <= clsr_pkg::GEN_TWO_RST;
      last_out_q  <= '0;
      out_data_q  <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      gen_one_q   <= gen_one_d;
      gen_two_q   <= gen_two_d;
      last_out_q  <= last_out_d;
      out_data_q  <= out_data_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rand_out_o  = out_data_q;

  a_draw_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW_C) && out_free |=> out_valid_o && (rand_out_o == last_out_q))
    else $error("completed draw did not load the output register");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rand_out_o != '0) && (rand_out_o <= clsr_pkg::OUT_MAX))
    else $error("result outside 1..OUT_MAX");

  a_gen_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW_C) |->
      (gen_one_q < clsr_pkg::MOD_ONE) && (gen_two_q < clsr_pkg::MOD_TWO))
    else $error("generator state not reduced after a step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> (state_q == S_SEED_MUL) || (state_q == S_DRAW_A))
    else $error("accepted transaction did not start work");

  a_seed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEED_RED) && (cnt_q != '0) |=>
      (state_q == S_SEED_MUL) && (cnt_q == $past(cnt_q) - CNTW'(1)))
    else $error("warm-up counter out of step");

endmodule
`default_nettype wire

>>> bench/combined_lcg_shuffle_rng_checker.sv
module combined_lcg_shuffle_rng_checker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       op_i,
  input  wire logic [clsr_pkg::VAL_W-1:0] seed_value_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [clsr_pkg::VAL_W-1:0] rand_out_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW       = clsr_pkg::VAL_W;
  localparam int unsigned BIN_SPAN = 1 + clsr_pkg::OUT_MAX / TABLE_DEPTH;

  logic [VW-1:0] gen_one_q;
  logic [VW-1:0] gen_two_q;
  logic [VW-1:0] last_draw_q;
  logic [VW-1:0] bins_q [TABLE_DEPTH];
  logic [VW-1:0] draws_due_q [$];
  int unsigned   mismatches;

  function automatic logic [VW-1:0] mod_mul(input logic [VW-1:0] x,
                                             input logic [15:0]   mul,
                                             input logic [VW-1:0] modulus);
    logic [63:0] prod;
    prod = 64'(x) * 64'(mul);
    return VW'(prod % 64'(modulus));
  endfunction

  task automatic reseed_bins(input logic [VW-1:0] seed);
    int j;
    gen_one_q = (seed == '0) ? clsr_pkg::SEED_ZERO_SUB : seed;
    gen_two_q = gen_one_q;
    for (j = TABLE_DEPTH + clsr_pkg::WARMUP_EXTRA - 1; j >= 0; j--) begin
      gen_one_q = mod_mul(gen_one_q, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
      if (j < TABLE_DEPTH) bins_q[j] = gen_one_q;
    end
    last_draw_q = bins_q[0];
  endtask

  task automatic shuffled_draw(output logic [VW-1:0] value);
    int unsigned pick;
    longint      diff;
    gen_one_q = mod_mul(gen_one_q, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
    gen_two_q = mod_mul(gen_two_q, clsr_pkg::MUL_TWO, clsr_pkg::MOD_TWO);
    pick = last_draw_q / BIN_SPAN;
    if (pick >= TABLE_DEPTH) pick = TABLE_DEPTH - 1;
    diff = longint'(bins_q[pick]) - longint'(gen_two_q);
    bins_q[pick] = gen_one_q;
    if (diff < 1) diff += longint'(clsr_pkg::OUT_MAX);
    last_draw_q = diff[VW-1:0];
    value = last_draw_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [VW-1:0] drawn;
    logic [VW-1:0] due;
    if (!rst_ni) begin
      gen_one_q   = clsr_pkg::GEN_ONE_RST;
      gen_two_q   = clsr_pkg::GEN_TWO_RST;
      last_draw_q = '0;
      foreach (bins_q[i]) bins_q[i] = '0;
      draws_due_q.delete();
      mismatches  = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (op_i == clsr_pkg::OP_SEED) reseed_bins(seed_value_i);
        shuffled_draw(drawn);
        draws_due_q.push_back(drawn);
      end
      if (out_valid_i && out_ready_i) begin
        if (draws_due_q.size() == 0) begin
          $display("%0t rand_out with no transaction pending: expected none actual %0d",
                   $time, rand_out_i);
          mismatches++;
        end else begin
          due = draws_due_q.pop_front();
          if (rand_out_i !== due) begin
            $display("%0t rand_out mismatch: expected %0d actual %0d",
                     $time, due, rand_out_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= draws_due_q.size();
  end

endmodule

>>> bench/combined_lcg_shuffle_rng_top_tb.sv
module combined_lcg_shuffle_rng_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW           = clsr_pkg::VAL_W;
  localparam int unsigned DEPTH        = 32;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 2 * (DEPTH + clsr_pkg::WARMUP_EXTRA) + 16;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           src_valid = 1'b0;
  clsr_pkg::op_e  src_op    = clsr_pkg::OP_DRAW;
  logic [VW-1:0]  src_seed  = '0;
  logic           sink_ready = 1'b0;
  logic           src_ready;
  logic           sink_valid;
  logic [VW-1:0]  sink_value;
  int unsigned    mismatch_count;
  int unsigned    pending_count;
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    stall_mode = 0;
  int unsigned    stall_tick = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  combined_lcg_shuffle_rng_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (src_valid),
    .in_ready_o  (src_ready),
    .op_i        (src_op),
    .seed_value_i(src_seed),
    .out_valid_o (sink_valid),
    .out_ready_i (sink_ready),
    .rand_out_o  (sink_value)
  );

  combined_lcg_shuffle_rng_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (src_valid),
    .in_ready_i      (src_ready),
    .op_i            (src_op),
    .seed_value_i    (src_seed),
    .out_valid_i     (sink_valid),
    .out_ready_i     (sink_ready),
    .rand_out_i      (sink_value),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_tick = $urandom_range(20, 80);
    end else begin
      stall_tick--;
    end
    case (stall_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= 1'($urandom_range(0, 1));
      2: sink_ready <= ($urandom_range(0, 3) == 0);
      default: sink_ready <= (stall_tick[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (src_valid && src_ready) || (sink_valid && sink_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // hold the transaction until accepted; drop valid only when a gap follows
  task automatic offer(input clsr_pkg::op_e op, input logic [VW-1:0] seed);
    src_valid <= 1'b1;
    src_op    <= op;
    src_seed  <= seed;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      src_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 24) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 15);
    end
  endtask

  function automatic logic [VW-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return VW'(1);
          2: return clsr_pkg::MOD_ONE;
          3: return clsr_pkg::MOD_TWO;
          4: return clsr_pkg::OUT_MAX;
          default: return '1;
        endcase
      end
      1, 2: return VW'($urandom_range(0, clsr_pkg::OUT_MAX));
      default: return VW'($urandom());
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    repeat (3) offer(clsr_pkg::OP_DRAW, VW'($urandom()));
    offer(clsr_pkg::OP_SEED, '0);
    repeat (2) offer(clsr_pkg::OP_DRAW, VW'($urandom()));
    offer(clsr_pkg::OP_SEED, VW'(1));
    offer(clsr_pkg::OP_SEED, clsr_pkg::OUT_MAX);
    offer(clsr_pkg::OP_SEED, clsr_pkg::MOD_ONE);
    repeat (2) offer(clsr_pkg::OP_DRAW, '1);
    offer(clsr_pkg::OP_SEED, clsr_pkg::MOD_TWO);
    repeat (2) offer(clsr_pkg::OP_DRAW, '0);
    offer(clsr_pkg::OP_SEED, '1);
    offer(clsr_pkg::OP_DRAW, VW'($urandom()));
    offer(clsr_pkg::OP_SEED, 31'h2AAA_AAAA);
    offer(clsr_pkg::OP_SEED, 31'h5555_5555);
    repeat (2) offer(clsr_pkg::OP_DRAW, VW'($urandom()));

    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) offer(clsr_pkg::OP_SEED, pick_seed());
      else offer(clsr_pkg::OP_DRAW, VW'($urandom()));
    end
    src_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/clsr_pkg.sv
rtl/clsr_ram.sv
rtl/clsr_mulmod.sv
rtl/clsr_bin.sv
rtl/combined_lcg_shuffle_rng_top.sv
bench/combined_lcg_shuffle_rng_checker.sv
bench/combined_lcg_shuffle_rng_top_tb.sv
